// ===== rtl/bre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_pkg
// Shared types, field widths and command codes of the bitmap range engine.
// ----------------------------------------------------------------------------
package bre_pkg;

	localparam int MAP_BITS_DEF  = 4096;
	localparam int WORD_BITS_DEF = 32;

	localparam int CMD_W   = 3;
	localparam int START_W = 12;
	localparam int LEN_W   = 13;
	localparam int OFF_W   = 12;
	localparam int POS_W   = 13;
	localparam int BCNT_W  = 7;

	localparam int IN_DATA_W  = 40;
	localparam int IN_USER_W  = 8;
	localparam int OUT_DATA_W = 32;

	localparam logic [CMD_W-1:0] CMD_SET   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TEST  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_COUNT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FIND  = 3'd4;

	typedef struct packed {
		logic [BCNT_W-1:0] pop;
		logic [BCNT_W-1:0] t_ones;
		logic [BCNT_W-1:0] l_ones;
		logic              hit;
		logic [BCNT_W-1:0] hit_pos;
	} bre_word_stat_t;

endpackage

// ===== rtl/bre_word_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bre_word_unit
// Per-word analysis: range mask, popcount, edge runs of ones, in-word run
// search and the set/clear write-back word.
// ----------------------------------------------------------------------------
module bre_word_unit import bre_pkg::*; #(
	parameter int WordBits = WORD_BITS_DEF
) (
	input  logic [WordBits-1:0]         data,
	input  logic [$clog2(WordBits)-1:0] lo,
	input  logic [$clog2(WordBits)-1:0] hi,
	input  logic [LEN_W-1:0]            run,
	input  logic                        setting,
	output logic [WordBits-1:0]         wr_data,
	output bre_word_stat_t              stat
);

	localparam int WL = $clog2(WordBits);

	logic [WordBits-1:0] mask;
	logic [WordBits-1:0] m;
	logic [WordBits-1:0] p [WL+1];
	logic [WordBits-1:0] acc;

	always_comb begin
		mask = ({WordBits{1'b1}} << lo) & ({WordBits{1'b1}} >> (WL'(WordBits - 1) - hi));
		m = data & mask;
		wr_data = setting ? (data | mask) : (data & ~mask);
	end

	always_comb begin
		stat.pop = '0;
		for (int i = 0; i < WordBits; i++) begin
			stat.pop = stat.pop + BCNT_W'(m[i]);
		end
		stat.t_ones = BCNT_W'(WordBits);
		for (int i = WordBits - 1; i >= 0; i--) begin
			if (!m[i]) begin
				stat.t_ones = BCNT_W'(i);
			end
		end
		stat.l_ones = BCNT_W'(WordBits);
		for (int i = 0; i < WordBits; i++) begin
			if (!m[i]) begin
				stat.l_ones = BCNT_W'(WordBits - 1 - i);
			end
		end

		// p[k] bit j: bits j .. j+2^k-1 all set
		p[0] = m;
		for (int k = 1; k <= WL; k++) begin
			p[k] = p[k-1] & (p[k-1] >> (1 << (k - 1)));
		end
		acc = {WordBits{1'b1}};
		for (int k = 0; k <= WL; k++) begin
			if (run[k]) begin
				acc = acc & (p[k] >> (run & LEN_W'((1 << k) - 1)));
			end
		end
		stat.hit = (run != '0) && (run <= LEN_W'(WordBits)) && (|acc);
		stat.hit_pos = '0;
		for (int i = WordBits - 1; i >= 0; i--) begin
			if (acc[i]) begin
				stat.hit_pos = BCNT_W'(i);
			end
		end
	end

endmodule

// ===== rtl/bitmap_range_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_range_engine_top
// Allocation bitmap held in a word memory; set, clear, test, count and
// first-fit run search over a bit range, one memory word per cycle.
//
//   channel  dir  payload (low bit up)
//   s_axis   in   tuser: command[2:0]
//                 tdata: start_req[11:0], length[24:12], run_length[37:25]
//   m_axis   out  tdata: found[0], bits_set[13:1], run_offset[25:14],
//                        range_error[26]
//
// A command reads each memory word the range touches in turn; errors, empty
// ranges and unknown commands read none and go straight to the result. The
// single memory port pair allows one word read, and for set or clear one
// word written back, each cycle. After reset a clearing pass writes zero to
// every memory word with s_axis_tready low. A waiting result holds the next
// result back; the next command is still accepted.
// ----------------------------------------------------------------------------
module bitmap_range_engine_top import bre_pkg::*; #(
	parameter int MapBits  = MAP_BITS_DEF,
	parameter int WordBits = WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // start_req, length, run_length
	input  logic [IN_USER_W-1:0]  s_axis_tuser,  // command
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // found, bits_set, run_offset, range_error
);

	localparam int WL        = $clog2(WordBits);
	localparam int NUM_WORDS = MapBits / WordBits;
	localparam int AW        = $clog2(NUM_WORDS);
	localparam int WIW       = POS_W - WL;

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	logic [WordBits-1:0] mem [NUM_WORDS];

	logic [1:0]          state_q;
	logic [AW-1:0]       clr_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [START_W-1:0]  start_q;
	logic [LEN_W-1:0]    run_q;
	logic                err_q;
	logic [WIW-1:0]      w_first_q, w_last_q, rd_idx_q;
	logic [WL-1:0]       lo_first_q, hi_last_q;
	logic                issued_q;
	logic                v_s1;
	logic [WIW-1:0]      widx_s1;
	logic [WordBits-1:0] rdata_s1;
	logic                any_q, found_q;
	logic [LEN_W-1:0]    cnt_q, streak_q;
	logic [OFF_W-1:0]    first_q, off_q;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic [CMD_W-1:0]    in_cmd;
	logic [START_W-1:0]  in_start;
	logic [LEN_W-1:0]    in_len;
	logic [LEN_W-1:0]    in_run;
	logic [POS_W-1:0]    in_end;
	logic                in_err, in_skip;

	logic                accept;
	logic                rd_en;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [WordBits-1:0] wdata;
	logic [WL-1:0]       cur_lo, cur_hi;
	logic [WordBits-1:0] wb_data;
	bre_word_stat_t      stat;

	logic [OFF_W-1:0]    base_off;
	logic [LEN_W-1:0]    i_a;
	logic                hit_a, full_word, find_on, last_word;
	logic                out_free;

	assign in_cmd   = s_axis_tuser[CMD_W-1:0];
	assign in_start = s_axis_tdata[START_W-1:0];
	assign in_len   = s_axis_tdata[START_W +: LEN_W];
	assign in_run   = s_axis_tdata[START_W+LEN_W +: LEN_W];
	assign in_end   = POS_W'(in_start) + POS_W'(in_len) - POS_W'(1);
	assign in_err   = (in_cmd <= CMD_FIND) &&
		((32'(in_start) + 32'(in_len)) > 32'(MapBits));
	assign in_skip  = (in_cmd > CMD_FIND) || in_err || (in_len == '0);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign rd_en     = (state_q == ST_RUN) && !issued_q;
	assign last_word = (widx_s1 == w_last_q);
	assign cur_lo    = (widx_s1 == w_first_q) ? lo_first_q : '0;
	assign cur_hi    = last_word ? hi_last_q : WL'(WordBits - 1);

	bre_word_unit #(
		.WordBits(WordBits)
	) u_word (
		.data    (rdata_s1),
		.lo      (cur_lo),
		.hi      (cur_hi),
		.run     (run_q),
		.setting (cmd_q == CMD_SET),
		.wr_data (wb_data),
		.stat    (stat)
	);

	always_comb begin
		if (state_q == ST_CLR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = v_s1 && ((cmd_q == CMD_SET) || (cmd_q == CMD_CLEAR));
			waddr = AW'(widx_s1);
			wdata = wb_data;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rdata_s1 <= mem[AW'(rd_idx_q)];
			widx_s1  <= rd_idx_q;
		end
	end

	// run search bookkeeping
	always_comb begin
		base_off  = OFF_W'({widx_s1, {WL{1'b0}}}) - start_q;
		i_a       = run_q - streak_q - LEN_W'(1);
		hit_a     = i_a < LEN_W'(stat.t_ones);
		full_word = (stat.t_ones == BCNT_W'(WordBits));
		find_on   = v_s1 && (cmd_q == CMD_FIND) && !found_q && (run_q != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			issued_q    <= 1'b0;
			v_s1        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						issued_q <= 1'b0;
						state_q  <= in_skip ? ST_FIN : ST_RUN;
					end
				end
				ST_RUN: begin
					if (rd_en && (rd_idx_q == w_last_q)) begin
						issued_q <= 1'b1;
					end
					if (v_s1 && last_word) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= in_cmd;
			start_q    <= in_start;
			run_q      <= in_run;
			err_q      <= in_err;
			w_first_q  <= WIW'(in_start[START_W-1:WL]);
			w_last_q   <= in_end[POS_W-1:WL];
			rd_idx_q   <= WIW'(in_start[START_W-1:WL]);
			lo_first_q <= in_start[WL-1:0];
			hi_last_q  <= in_end[WL-1:0];
			any_q      <= 1'b0;
			found_q    <= 1'b0;
			cnt_q      <= '0;
			streak_q   <= '0;
			first_q    <= '0;
			off_q      <= '0;
		end else begin
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + WIW'(1);
			end
			if (v_s1) begin
				cnt_q <= cnt_q + LEN_W'(stat.pop);
				if (stat.pop != '0) begin
					any_q <= 1'b1;
				end
			end
			if (find_on) begin
				if (hit_a) begin
					found_q <= 1'b1;
					off_q   <= (streak_q == '0) ? base_off : first_q;
				end else if (stat.hit) begin
					found_q <= 1'b1;
					off_q   <= base_off + OFF_W'(stat.hit_pos);
				end
				if (full_word) begin
					streak_q <= streak_q + LEN_W'(WordBits);
					if (streak_q == '0) begin
						first_q <= base_off;
					end
				end else begin
					streak_q <= LEN_W'(stat.l_ones);
					first_q  <= base_off + OFF_W'(WordBits) - OFF_W'(stat.l_ones);
				end
			end
		end
		if ((state_q == ST_FIN) && out_free) begin
			out_data_q <= {{(OUT_DATA_W - LEN_W - OFF_W - 2){1'b0}}, err_q,
				(((cmd_q == CMD_FIND) && found_q) ? off_q : OFF_W'(0)),
				((cmd_q == CMD_COUNT) ? cnt_q : LEN_W'(0)),
				(((cmd_q == CMD_TEST) && any_q) || ((cmd_q == CMD_FIND) && found_q))};
		end
	end

endmodule

// ===== test/bitmap_range_engine_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_range_engine_top_tb
// Self-checking bench for the allocation bitmap range engine. A shadow copy
// of the bitmap predicts every reply. Commands go in through a bursty driver
// and replies come out against a receiver that stalls in shifting patterns.
// The stimulus starts with a directed set of corner commands: full map,
// last bit, empty ranges, zero and oversize runs, out-of-range and unknown
// commands. It then runs random phases that focus on a moving window so that
// sets, clears and run searches overlap.
// ----------------------------------------------------------------------------
module bitmap_range_engine_top_tb;
	import bre_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int RAND_PHASES   = 5;
	localparam int PHASE_CMDS    = 270;
	localparam int LONG_HOLD     = 500;
	localparam int HOLD_INTERVAL = 400;
	localparam int CMD_CODES     = 1 << CMD_W;

	typedef struct {
		logic [CMD_W-1:0]   cmd;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic [LEN_W-1:0]   run;
	} range_cmd_t;

	typedef struct {
		logic             found;
		logic [LEN_W-1:0] bits_set;
		logic [OFF_W-1:0] run_offset;
		logic             range_error;
	} range_reply_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata;
	logic [IN_USER_W-1:0]  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	bitmap_range_engine_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	logic [MAP_BITS_DEF-1:0] map_shadow;
	range_cmd_t              cmd_backlog[$];
	range_reply_t            reply_due[$];
	range_cmd_t              bus_cmd;

	int n_fail;
	int n_accepted;
	int n_sent;
	int n_replies;
	int n_found;
	int n_range_err;
	int n_holds;
	int n_per_cmd[CMD_CODES];
	int cycles;

	// shadow bitmap: one command in, one reply out
	function automatic range_reply_t apply_range_cmd(range_cmd_t c);
		range_reply_t r;
		int           i;
		int           streak;
		int           first_i;
		r = '{default: '0};
		streak = 0;
		first_i = 0;
		if (c.cmd <= CMD_FIND) begin
			if (int'(c.start) + int'(c.len) > MAP_BITS_DEF) begin
				r.range_error = 1'b1;
			end else begin
				case (c.cmd)
					CMD_SET, CMD_CLEAR: begin
						for (i = 0; i < int'(c.len); i++)
							map_shadow[int'(c.start) + i] = (c.cmd == CMD_SET);
					end
					CMD_TEST: begin
						for (i = 0; i < int'(c.len); i++)
							if (map_shadow[int'(c.start) + i])
								r.found = 1'b1;
					end
					CMD_COUNT: begin
						for (i = 0; i < int'(c.len); i++)
							if (map_shadow[int'(c.start) + i])
								r.bits_set = r.bits_set + LEN_W'(1);
					end
					default: begin
						if (c.run != 0) begin
							for (i = 0; i < int'(c.len) && !r.found; i++) begin
								if (map_shadow[int'(c.start) + i]) begin
									streak++;
									if (streak == 1)
										first_i = i;
									if (streak == int'(c.run)) begin
										r.found = 1'b1;
										r.run_offset = first_i[OFF_W-1:0];
									end
								end else begin
									streak = 0;
								end
							end
						end
					end
				endcase
			end
		end
		return r;
	endfunction

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input int start, input int len,
			input int run);
		range_cmd_t c;
		c.cmd = cmd;
		c.start = start[START_W-1:0];
		c.len = len[LEN_W-1:0];
		c.run = run[LEN_W-1:0];
		cmd_backlog.push_back(c);
	endtask

	function automatic range_cmd_t random_cmd(int base);
		range_cmd_t c;
		int         pick;
		int         start;
		int         len;
		pick = $urandom_range(0, 99);
		if (pick < 20)
			c.cmd = CMD_SET;
		else if (pick < 35)
			c.cmd = CMD_CLEAR;
		else if (pick < 50)
			c.cmd = CMD_TEST;
		else if (pick < 70)
			c.cmd = CMD_COUNT;
		else if (pick < 95)
			c.cmd = CMD_FIND;
		else
			c.cmd = CMD_W'($urandom_range(int'(CMD_FIND) + 1, CMD_CODES - 1));

		if ($urandom_range(0, 9) < 7)
			start = (base + $urandom_range(0, 511)) % MAP_BITS_DEF;
		else
			start = $urandom_range(0, MAP_BITS_DEF - 1);

		pick = $urandom_range(0, 99);
		if (pick < 55)
			len = $urandom_range(0, 64);
		else if (pick < 80)
			len = $urandom_range(65, 600);
		else if (pick < 90)
			len = $urandom_range(0, MAP_BITS_DEF - start);
		else if (pick < 95)
			len = MAP_BITS_DEF - start + 1;
		else
			len = $urandom_range(0, (1 << LEN_W) - 1);

		c.start = start[START_W-1:0];
		c.len = len[LEN_W-1:0];

		pick = $urandom_range(0, 99);
		if (pick < 65)
			c.run = LEN_W'($urandom_range(1, 12));
		else if (pick < 80)
			c.run = LEN_W'($urandom_range(1, (len % (1 << LEN_W)) + 1));
		else if (pick < 88)
			c.run = '0;
		else
			c.run = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
		return c;
	endfunction

	function automatic void check_field(string name, int exp_v, int got_v);
		if (exp_v != got_v) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
			n_fail++;
		end
	endfunction

	task automatic wait_drained;
		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || s_axis_tvalid || reply_due.size() != 0);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d replies still due", $time, reply_due.size());
			$display("bitmap_range_engine_top_tb: FAIL");
			$finish;
		end
	end

	// monitor: input acceptance feeds the shadow map, output beats are checked
	always @(posedge clk) begin : monitor
		range_reply_t got;
		range_reply_t want;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			reply_due.push_back(apply_range_cmd(bus_cmd));
			n_per_cmd[bus_cmd.cmd]++;
			n_accepted++;
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.found = m_axis_tdata[0];
			got.bits_set = m_axis_tdata[13:1];
			got.run_offset = m_axis_tdata[25:14];
			got.range_error = m_axis_tdata[26];
			n_replies++;
			if (reply_due.size() == 0) begin
				$display("%0t: unexpected reply beat, expected none, actual %h", $time,
					m_axis_tdata);
				n_fail++;
			end else begin
				want = reply_due.pop_front();
				check_field("found", int'(want.found), int'(got.found));
				check_field("bits_set", int'(want.bits_set), int'(got.bits_set));
				check_field("run_offset", int'(want.run_offset), int'(got.run_offset));
				check_field("range_error", int'(want.range_error), int'(got.range_error));
				n_found += int'(want.found);
				n_range_err += int'(want.range_error);
			end
		end
	end

	// driver: bursts of commands with random gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin : driver
		bit next_valid;
		bit busy;
		if (arst_n) begin
			busy = s_axis_tvalid && (n_sent != n_accepted);
			if (!busy) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_backlog.size() > 0) begin
					bus_cmd = cmd_backlog.pop_front();
					n_sent++;
					next_valid = 1'b1;
					s_axis_tdata <= {{(IN_DATA_W - START_W - 2 * LEN_W){1'b0}},
						bus_cmd.run, bus_cmd.len, bus_cmd.start};
					s_axis_tuser <= {{(IN_USER_W - CMD_W){1'b0}}, bus_cmd.cmd};
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						case ($urandom_range(0, 7))
							0, 1, 2: gap_left = 0;
							7:       gap_left = $urandom_range(20, 40);
							default: gap_left = $urandom_range(1, 8);
						endcase
					end
				end
				s_axis_tvalid <= next_valid;
			end
		end
	end

	// receiver: pattern stalls plus a long hold-off every HOLD_INTERVAL accepted commands, at most twice
	int hold_left = 0;
	int sink_mode = 0;
	int mode_left = 0;
	int sink_tick = 0;

	always @(negedge clk) begin : receiver
		if (arst_n) begin
			sink_tick++;
			if (n_holds < 2 && n_accepted >= HOLD_INTERVAL * (n_holds + 1)) begin
				hold_left = LONG_HOLD;
				n_holds++;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					sink_mode = $urandom_range(0, 3);
					mode_left = $urandom_range(16, 96);
				end else begin
					mode_left--;
				end
				case (sink_mode)
					0:       m_axis_tready <= 1'b1;
					1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
					2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (sink_tick % 7) >= 3;
				endcase
			end
		end
	end

	initial begin : main
		int base;
		int p;
		int k;
		map_shadow = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// directed corners
		queue_cmd(CMD_COUNT, 0, MAP_BITS_DEF, 0);
		queue_cmd(CMD_TEST, 0, MAP_BITS_DEF, 0);
		queue_cmd(CMD_SET, 0, MAP_BITS_DEF, 0);
		queue_cmd(CMD_COUNT, 0, MAP_BITS_DEF, 0);
		queue_cmd(CMD_FIND, 0, MAP_BITS_DEF, MAP_BITS_DEF);
		queue_cmd(CMD_FIND, 0, MAP_BITS_DEF, MAP_BITS_DEF + 1);
		queue_cmd(CMD_FIND, 0, MAP_BITS_DEF, 0);
		queue_cmd(CMD_CLEAR, 0, MAP_BITS_DEF - 1, 0);
		queue_cmd(CMD_FIND, 0, MAP_BITS_DEF, 1);
		queue_cmd(CMD_TEST, MAP_BITS_DEF - 1, 1, 0);
		queue_cmd(CMD_TEST, MAP_BITS_DEF - 2, 1, 0);
		queue_cmd(CMD_SET, MAP_BITS_DEF - 1, 2, 0);
		queue_cmd(CMD_COUNT, MAP_BITS_DEF - 1, 1, 0);
		queue_cmd(CMD_SET, 0, (1 << LEN_W) - 1, 0);
		queue_cmd(CMD_CLEAR, MAP_BITS_DEF - 1, MAP_BITS_DEF, 0);
		queue_cmd(CMD_SET, 100, 0, 0);
		queue_cmd(CMD_TEST, MAP_BITS_DEF - 1, 0, 0);
		queue_cmd(CMD_COUNT, MAP_BITS_DEF - 1, 0, 0);
		queue_cmd(CMD_FIND, MAP_BITS_DEF - 1, 0, 1);
		queue_cmd(CMD_SET, 2000, 40, 0);
		queue_cmd(CMD_FIND, 0, MAP_BITS_DEF, 40);
		queue_cmd(CMD_FIND, 2005, 30, 30);
		queue_cmd(CMD_FIND, 2000, 39, 40);
		queue_cmd(CMD_FIND, 0, MAP_BITS_DEF, (1 << LEN_W) - 1);
		for (k = CMD_FIND + 1; k < CMD_CODES; k++)
			queue_cmd(CMD_W'(k), MAP_BITS_DEF - 1, (1 << LEN_W) - 1, (1 << LEN_W) - 1);
		wait_drained();

		for (p = 0; p < RAND_PHASES; p++) begin
			base = $urandom_range(0, MAP_BITS_DEF - 1);
			for (k = 0; k < PHASE_CMDS; k++)
				cmd_backlog.push_back(random_cmd(base));
			wait_drained();
		end

		repeat (200) @(posedge clk);
		$display("covered %0d commands: set %0d, clear %0d, test %0d, count %0d, find %0d, other %0d",
			n_accepted, n_per_cmd[CMD_SET], n_per_cmd[CMD_CLEAR], n_per_cmd[CMD_TEST],
			n_per_cmd[CMD_COUNT], n_per_cmd[CMD_FIND],
			n_accepted - n_per_cmd[CMD_SET] - n_per_cmd[CMD_CLEAR] - n_per_cmd[CMD_TEST]
			- n_per_cmd[CMD_COUNT] - n_per_cmd[CMD_FIND]);
		$display("%0d replies checked, %0d hits, %0d range errors, %0d long output holds",
			n_replies, n_found, n_range_err, n_holds);
		if (n_fail == 0 && reply_due.size() == 0) begin
			$display("bitmap_range_engine_top_tb: PASS");
		end else begin
			$display("bitmap_range_engine_top_tb: FAIL");
		end
		$finish;
	end

endmodule
